// ===== hw/rtl/chunked_body_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_ASSERT_SVH
`define CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared types, byte codes and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	localparam int SIZE_BITS_DEF = 32;
	localparam int LIMIT_BITS    = 32;
	localparam int BYTE_BITS     = 8;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 32'd1000000;

	localparam logic [BYTE_BITS-1:0] CH_TAB = 8'h09;
	localparam logic [BYTE_BITS-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_BITS-1:0] CH_VT  = 8'h0B;
	localparam logic [BYTE_BITS-1:0] CH_FF  = 8'h0C;
	localparam logic [BYTE_BITS-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_BITS-1:0] CH_SP  = 8'h20;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_AFTER,
		PH_AFTER_CR,
		PH_STOPPED
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN      = 3'd0,
		ST_DONE     = 3'd1,
		ST_BADHDR   = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_LIMIT    = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 out_valid;
		status_t              status;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [BYTE_BITS-1:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic is_space(input logic [BYTE_BITS-1:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbd_engine.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder engine
// Decoder state and the per-byte update; result is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunked_body_decoder_assert.svh"

module cbd_engine #(
	parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step_en,
	input  wire logic [cbd_pkg::BYTE_BITS-1:0]    in_byte,
	input  wire logic [cbd_pkg::LIMIT_BITS-1:0]   body_limit,
	output cbd_pkg::result_t                      res
);
	import cbd_pkg::*;

	localparam int SUM_BITS = ((SIZE_BITS > LIMIT_BITS) ? SIZE_BITS : LIMIT_BITS) + 1;

	phase_t                phase_q, phase_d;
	status_t               held_q, held_d;
	logic [SIZE_BITS-1:0]  chunk_q, chunk_d;
	logic [SIZE_BITS-1:0]  acc_q, acc_d;
	logic [LIMIT_BITS-1:0] sum_q, sum_d;
	logic                  dig_q, dig_d;
	logic                  ign_q, ign_d;
	logic                  bad_q, bad_d;
	logic                  cr_q, cr_d;

	logic [SUM_BITS-1:0]   sum_w;
	logic [SIZE_BITS-1:0]  chunk_dec;
	logic                  clr, hdr, ign1;
	hex_t                  hx;

	assign sum_w     = SUM_BITS'(sum_q) + SUM_BITS'(acc_q);
	assign chunk_dec = (chunk_q != '0) ? chunk_q - SIZE_BITS'(1) : chunk_q;
	assign hx        = hex_decode(in_byte);

	// next state
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		chunk_d = chunk_q;
		sum_d   = sum_q;
		acc_d   = acc_q;
		dig_d   = dig_q;
		ign_d   = ign_q;
		bad_d   = bad_q;
		cr_d    = cr_q;
		clr     = 1'b0;
		hdr     = 1'b0;
		ign1    = 1'b0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				chunk_d = chunk_dec;
				if (chunk_dec == '0) phase_d = PH_AFTER;
			end
			PH_AFTER: begin
				if (in_byte == CH_CR) begin
					phase_d = PH_AFTER_CR;
				end else if (in_byte == CH_LF) begin
					phase_d = PH_HEADER;
					clr     = 1'b1;
				end else begin
					clr = 1'b1;
					hdr = 1'b1;
				end
			end
			PH_AFTER_CR: begin
				phase_d = PH_HEADER;
				clr     = 1'b1;
				hdr     = (in_byte != CH_LF);
			end
			PH_HEADER: hdr = 1'b1;
			default: ;
		endcase

		if (clr) begin
			acc_d = '0;
			dig_d = 1'b0;
			ign_d = 1'b0;
			bad_d = 1'b0;
			cr_d  = 1'b0;
		end

		if (hdr) begin
			phase_d = PH_HEADER;
			if (cr_d && in_byte == CH_LF) begin
				// end of header line
				acc_d = '0;
				dig_d = 1'b0;
				ign_d = 1'b0;
				bad_d = 1'b0;
				cr_d  = 1'b0;
				if (bad_q || !dig_q) begin
					phase_d = PH_STOPPED;
					held_d  = ST_BADHDR;
				end else if (sum_w > SUM_BITS'(body_limit)) begin
					phase_d = PH_STOPPED;
					held_d  = ST_LIMIT;
				end else if (acc_q == '0) begin
					phase_d = PH_STOPPED;
					held_d  = ST_DONE;
				end else begin
					chunk_d = acc_q;
					sum_d   = sum_w[LIMIT_BITS-1:0];
					phase_d = PH_PAYLOAD;
				end
			end else begin
				// a pending lone CR counts as whitespace of the line
				ign1  = ign_d | (cr_d & dig_d);
				ign_d = ign1;
				cr_d  = (in_byte == CH_CR);
				if (in_byte != CH_CR && !ign1) begin
					if (hx.ok) begin
						if (acc_d[SIZE_BITS-1 -: 4] != 4'd0) begin
							phase_d = PH_STOPPED;
							held_d  = ST_OVERFLOW;
						end else begin
							acc_d = {acc_d[SIZE_BITS-5:0], hx.val};
							dig_d = 1'b1;
						end
					end else if (is_space(in_byte)) begin
						if (dig_d) ign_d = 1'b1;
					end else begin
						bad_d = 1'b1;
						ign_d = 1'b1;
					end
				end
			end
		end
	end

	// result
	always_comb begin
		res.out_valid = (phase_q == PH_PAYLOAD);
		res.out_byte  = (phase_q == PH_PAYLOAD) ? in_byte : '0;
		res.status    = (phase_d == PH_STOPPED) ? held_d : ST_RUN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			held_q  <= ST_RUN;
			chunk_q <= '0;
			acc_q   <= '0;
			sum_q   <= '0;
			dig_q   <= 1'b0;
			ign_q   <= 1'b0;
			bad_q   <= 1'b0;
			cr_q    <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			chunk_q <= chunk_d;
			acc_q   <= acc_d;
			sum_q   <= sum_d;
			dig_q   <= dig_d;
			ign_q   <= ign_d;
			bad_q   <= bad_d;
			cr_q    <= cr_d;
		end
	end

	`CBD_ASSERT_NEXT(a_stop_holds, clk, arst_n, phase_q == PH_STOPPED, phase_q == PH_STOPPED, "stopped state left")
	`CBD_ASSERT_SAME(a_stop_status, clk, arst_n, phase_q == PH_STOPPED, held_q != ST_RUN, "stopped without status")
	`CBD_ASSERT_SAME(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, chunk_q != '0, "payload with empty chunk")
	`CBD_ASSERT_SAME(a_ignore_cause, clk, arst_n, ign_q && !bad_q, dig_q, "line ignored without digits")

endmodule

`default_nettype wire

// ===== hw/rtl/chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder
// Decodes an HTTP/1.1 chunked body, one byte per word.
// ----------------------------------------------------------------------------
// Input stream: s_tdata[7:0] is the raw body byte. Output stream: one word per
// input word; m_tdata[7:0] is the payload byte (zero when not payload),
// m_tuser[0] flags payload, m_tuser[3:1] is the status (0 running,
// 1 complete, 2 bad header, 3 size overflow, 4 limit exceeded).
// cfg_data sets the body limit; cfg_ready is always high. Write it only
// while no word is in flight.
// A word accepted into the input register is decoded from there, and the
// decode logic loads the result into the output register, raising m_tvalid.
// Throughput is one word per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its word and the
// input register fills; s_tready drops once both are full.
// Reset empties both registers, returns to the header phase and sets the
// body limit to 1000000. Complete and error states hold until reset.
`default_nettype none

module chunked_body_decoder #(
	parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic [3:0]       m_tuser,   // out_valid, status[2:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	import cbd_pkg::*;

	logic                  valid_s1;
	logic [BYTE_BITS-1:0]  byte_s1;
	logic                  m_valid_q;
	result_t               res_q;
	result_t               res;
	logic                  advance;
	logic [LIMIT_BITS-1:0] limit_q;

	assign advance   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = res_q.out_byte;
	assign m_tuser   = {res_q.status, res_q.out_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	cbd_engine #(
		.SIZE_BITS (SIZE_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.in_byte    (byte_s1),
		.body_limit (limit_q),
		.res        (res)
	);

endmodule

`default_nettype wire

// ===== dv/tb_chunked_body_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Streams chunked bodies through the decoder one byte per word, with random
// gaps on both sides and one long output stall. An in-bench decoder predicts
// every output word, and each word that leaves the block is checked against
// it. The run ends in one stop condition picked at random, then checks that
// the stop status holds.
// ----------------------------------------------------------------------------
module tb_chunked_body_decoder;
	import cbd_pkg::*;

	localparam int SZ         = SIZE_BITS_DEF;
	localparam int WDOG_LIMIT = 2000;
	localparam logic [7:0] WS_SET [6] = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // in_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // out_byte
	logic [3:0]  m_tuser;          // out_valid, status[2:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;

	chunked_body_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// decoder state as predicted
	phase_t         ph;
	logic [SZ-1:0]  left_cnt;
	logic [32:0]    total_sz;
	logic [SZ-1:0]  cur_size;
	bit             got_digit, skip_rest, bad_line, pend_cr;
	status_t        stop_code;
	logic [31:0]    limit_reg;

	result_t        decoded_q[$];

	bit          tx_steady, rx_steady;
	int          hold_req;
	logic [7:0]  last_byte;
	longint      sent_total;
	int          n_in, n_chunks, n_payload, n_cfg, n_err, n_in_stall, quiet;

	function automatic void clear_hdr();
		cur_size  = '0;
		got_digit = 1'b0;
		skip_rest = 1'b0;
		bad_line  = 1'b0;
		pend_cr   = 1'b0;
	endfunction

	function automatic void halt(input status_t s);
		stop_code = s;
		ph        = PH_STOPPED;
	endfunction

	// one byte of the size line, not the closing CR LF
	function automatic void line_byte(input logic [7:0] c);
		logic [3:0] nib;
		bit is_hex;
		if (skip_rest)
			return;
		is_hex = 1'b1;
		nib    = '0;
		if (c >= "0" && c <= "9")
			nib = 4'(c - "0");
		else if (c >= "a" && c <= "f")
			nib = 4'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F")
			nib = 4'(c - "A" + 8'd10);
		else
			is_hex = 1'b0;
		if (is_hex) begin
			if (cur_size[SZ-1 -: 4] != 4'd0) begin
				halt(ST_OVERFLOW);
				return;
			end
			cur_size  = {cur_size[SZ-5:0], nib};
			got_digit = 1'b1;
		end else if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
				c == CH_FF || c == CH_CR) begin
			if (got_digit)
				skip_rest = 1'b1;
		end else begin
			bad_line  = 1'b1;
			skip_rest = 1'b1;
		end
	endfunction

	function automatic void header_in(input logic [7:0] c);
		logic [SZ-1:0] sz;
		bit bad;
		ph = PH_HEADER;
		if (pend_cr) begin
			if (c == CH_LF) begin
				sz  = cur_size;
				bad = bad_line || !got_digit;
				clear_hdr();
				if (bad) begin
					halt(ST_BADHDR);
				end else begin
					total_sz = total_sz + 33'(sz);
					// limit check comes ahead of the last-chunk test
					if (total_sz > {1'b0, limit_reg})
						halt(ST_LIMIT);
					else if (sz == '0)
						halt(ST_DONE);
					else begin
						left_cnt = sz;
						ph       = PH_PAYLOAD;
					end
				end
				return;
			end
			// CR without LF counts as whitespace in the line
			pend_cr = 1'b0;
			line_byte(CH_CR);
			if (ph == PH_STOPPED)
				return;
		end
		if (c == CH_CR)
			pend_cr = 1'b1;
		else
			line_byte(c);
	endfunction

	function automatic result_t decode_byte(input logic [7:0] c);
		result_t r;
		r.out_byte  = '0;
		r.out_valid = 1'b0;
		case (ph)
			PH_PAYLOAD: begin
				r.out_byte  = c;
				r.out_valid = 1'b1;
				if (left_cnt != '0)
					left_cnt--;
				if (left_cnt == '0)
					ph = PH_AFTER;
			end
			PH_AFTER, PH_AFTER_CR: begin
				if (c == CH_CR && ph == PH_AFTER)
					ph = PH_AFTER_CR;
				else if (c == CH_LF) begin
					ph = PH_HEADER;
					clear_hdr();
				end else begin
					clear_hdr();
					header_in(c);
				end
			end
			PH_HEADER: header_in(c);
			default: ;
		endcase
		r.status = (ph == PH_STOPPED) ? stop_code : ST_RUN;
		return r;
	endfunction

	function automatic int pick_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 40);
		return $urandom_range(41, 120);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(tx_steady);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (!s_tready);
		decoded_q = {decoded_q, decode_byte(b)};
		last_byte = b;
		n_in++;
	endtask

	// drop valid and wait until every predicted word has come out
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] v);
		settle();
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_header(input logic [31:0] size, input bit with_ext);
		int need, nd, nlead;
		logic [7:0] c;
		logic [3:0] nib;
		need = 1;
		for (int i = 1; i < 8; i++)
			if ((size >> (4 * i)) != 0)
				need = i + 1;
		nd = need;
		if ($urandom_range(0, 7) == 0)
			nd = $urandom_range(need, 8);
		nlead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (nlead) begin
			c = WS_SET[$urandom_range(0, 5)];
			// LF right after CR would close an empty line
			if (c == CH_LF && last_byte == CH_CR)
				c = CH_SP;
			send_byte(c);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			nib = size[4*i +: 4];
			if (nib < 4'd10)
				c = "0" + nib;
			else
				c = ($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10;
			send_byte(c);
		end
		if (with_ext) begin
			send_byte(WS_SET[$urandom_range(0, 5)]);
			repeat ($urandom_range(0, 6)) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_LF)
					c = CH_SP;
				send_byte(c);
			end
		end
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_chunk(input int size);
		send_header(size, $urandom_range(0, 3) == 0);
		repeat (size) send_byte(8'($urandom_range(0, 255)));
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
			3: send_byte(CH_LF);
			4: send_byte(CH_CR);
			default: ;
		endcase
		sent_total += size;
		n_chunks++;
	endtask

	task automatic test_limit_low();
		logic [7:0] seq[$];
		write_limit(32'd1);
		// a one-byte chunk lands exactly on the limit
		seq = {"1", CH_CR, CH_LF, 8'hFF, CH_CR, CH_LF};
		foreach (seq[i]) send_byte(seq[i]);
		sent_total += 1;
		n_chunks++;
		write_limit(32'hFFFF_FFFF);
	endtask

	task automatic test_header_forms();
		logic [7:0] seq[$];
		seq = {CH_VT, "2", CH_SP, "z", "!", CH_CR, CH_LF, 8'h00, 8'hFF, CH_LF,
			"3", CH_CR, "!", CH_CR, CH_LF, 8'h55, 8'hAA, 8'h01, CH_CR,
			"0", "0", "0", "0", "0", "0", "0", "1", CH_CR, CH_CR, CH_LF, 8'h7F};
		foreach (seq[i]) send_byte(seq[i]);
		sent_total += 6;
		n_chunks += 3;
	endtask

	task automatic test_random_chunks(input int n_items);
		int stop_at;
		stop_at = n_in + n_items;
		while (n_in < stop_at) begin
			tx_steady = ($urandom_range(0, 5) == 0);
			send_chunk(pick_size());
		end
		tx_steady = 1'b0;
	endtask

	task automatic test_backpressure();
		tx_steady = 1'b1;
		hold_req  = 60;
		send_chunk(48);
		tx_steady = 1'b0;
	endtask

	task automatic test_tight_limit();
		int room, sz;
		room = $urandom_range(40, 120);
		write_limit(32'(sent_total + room));
		while (room > 16) begin
			sz = $urandom_range(1, 16);
			send_chunk(sz);
			room -= sz;
		end
		// last chunk fills the limit exactly
		send_chunk(room);
	endtask

	task automatic test_terminal();
		logic [7:0] seq[$];
		case ($urandom_range(0, 5))
			0: seq = {"0", CH_CR, CH_LF};
			1: seq = {"1", "g", CH_CR, CH_LF};
			2: seq = {CH_SP, CH_CR, CH_LF};
			3: seq = {"1", "2", "3", "4", "5", "6", "7", "8", "9"};
			4: begin
				write_limit(32'd0);
				seq = {"1", CH_CR, CH_LF};
			end
			default: seq = {"f", "F", "f", "f", "F", "f", "f", "f", CH_CR, CH_LF};
		endcase
		foreach (seq[i]) send_byte(seq[i]);
		// status must hold from here on
		repeat (12) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin : rx_side
		int wait_left, hold_left;
		result_t want;
		wait_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else if (wait_left > 0) begin
				m_tready = 1'b0;
				wait_left--;
			end else begin
				m_tready = 1'b1;
				if ($urandom_range(0, 40) == 0)
					rx_steady = !rx_steady;
				wait_left = pick_gap(rx_steady);
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (m_tuser[0])
					n_payload++;
				if (decoded_q.size() == 0) begin
					n_err++;
					$display("%0t: word with nothing expected: byte=%02h user=%h",
						$time, m_tdata, m_tuser);
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata !== want.out_byte || m_tuser[0] !== want.out_valid ||
							m_tuser[3:1] !== want.status) begin
						n_err++;
						$display("%0t: expected byte=%02h valid=%0d status=%0d, got byte=%02h valid=%0d status=%0d",
							$time, want.out_byte, want.out_valid, want.status,
							m_tdata, m_tuser[0], m_tuser[3:1]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (s_tvalid && !s_tready)
			n_in_stall++;
		if (quiet >= WDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : main
		ph        = PH_HEADER;
		left_cnt  = '0;
		total_sz  = '0;
		stop_code = ST_RUN;
		limit_reg = LIMIT_RESET;
		clear_hdr();
		last_byte = '0;
		hold_req  = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_limit_low();
		test_header_forms();
		test_random_chunks(300);
		test_backpressure();
		test_tight_limit();
		write_limit(32'h8000_0000);
		test_random_chunks(220);
		test_terminal();

		settle();
		repeat (8) @(posedge clk);
		$display("sent %0d words in %0d chunks, %0d payload words out, %0d limit writes",
			n_in, n_chunks, n_payload, n_cfg);
		$display("input held off %0d cycles; decoder stopped with %s",
			n_in_stall, stop_code.name());
		if (n_err == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== chunked_body_decoder.f =====
+incdir+hw/rtl
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_engine.sv
hw/rtl/chunked_body_decoder.sv
dv/tb_chunked_body_decoder.sv
